// File: rtl/core/lmwf_pkg.sv
package lmwf_pkg;

  localparam int PIXEL_W     = 8;
  localparam int MW_W        = 5;
  localparam int THR_W       = 8;
  localparam int DIM_W       = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MARKER_WIDTH   = 2'd0,
    REG_EDGE_THRESHOLD = 2'd1,
    REG_IMAGE_COLUMNS  = 2'd2,
    REG_IMAGE_ROWS     = 2'd3
  } cfg_reg_t;

  // register values after reset
  localparam logic [MW_W-1:0]  MARKER_WIDTH_RST   = 5'd10;
  localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 8'd40;
  localparam logic [DIM_W-1:0] IMAGE_COLUMNS_RST  = 13'd800;
  localparam logic [DIM_W-1:0] IMAGE_ROWS_RST     = 13'd600;

  // marking pixel levels
  localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

endpackage

// File: rtl/core/lmwf_ram.sv
module lmwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/lane_marking_width_filter.sv
// channel   dir  signals                         word contents (low bit first)
// s_axis    in   tvalid tready tdata tuser       tdata: pixel[7:0]; tuser: frame_start
// m_axis    out  tvalid tready tdata tuser tlast tdata: edge_value[7:0];
//                                                tuser: row_end, frame_end; tlast: run_last
// cfg       in   cfg_valid cfg_ready cfg_index   cfg_data: register value, low bits used
//                cfg_data
//
// one pixel per clock while s_axis_tready is high; a result word passes the issue, read
// and output registers; at the last column of a row the flush sends W+1 words (fewer on
// short rows), one per cycle through the window read ports unless m_axis stalls, and
// s_axis_tready stays low until the last of them is issued
// reset is synchronous; it clears counters, pointers, valids and the registers,
// the pixel window needs no clearing pass since only pixels of the current row are read
// an m_axis stall freezes the read and output stages; a new pixel is still taken
// while a result waits, as long as the issue stage has room
module lane_marking_width_filter #(
  parameter int MAX_MARKER_WIDTH = 31,
  parameter int MAX_DIMENSION    = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lmwf_pkg::PIXEL_W-1:0]        s_axis_tdata,   // pixel[7:0]
  input  logic                                s_axis_tuser,   // frame_start
  // marking output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lmwf_pkg::PIXEL_W-1:0]        m_axis_tdata,   // edge_value[7:0]
  output logic [1:0]                          m_axis_tuser,   // [0] row_end, [1] frame_end
  output logic                                m_axis_tlast,   // run_last
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmwf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lmwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W     = $clog2(MAX_DIMENSION);
  localparam int EXT_W     = CNT_W + 1;
  localparam int WIN_DEPTH = 2 ** $clog2(2 * MAX_MARKER_WIDTH + 1);
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int MW_W      = lmwf_pkg::MW_W;
  localparam int PW        = lmwf_pkg::PIXEL_W;

  typedef struct packed {
    logic ok;
    logic row_end;
    logic frame_end;
    logic run_last;
  } s1_flags_t;

  // configuration registers
  logic [MW_W-1:0]                marker_width;
  logic [lmwf_pkg::THR_W-1:0]     edge_threshold;
  logic [lmwf_pkg::DIM_W-1:0]     image_columns;
  logic [lmwf_pkg::DIM_W-1:0]     image_rows;

  // raster position and window write pointer
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [AW-1:0]    wp;

  // issue stage: at most one job per pixel, walks the result columns
  logic             s0_valid;
  logic [CNT_W-1:0] s0_x;
  logic [CNT_W-1:0] s0_last;
  logic [CNT_W-1:0] s0_c;
  logic [CNT_W-1:0] s0_r;
  logic [AW-1:0]    s0_wp;

  // read stage
  logic       s1_valid;
  s1_flags_t  s1;
  s1_flags_t  s1_next;

  logic [PW-1:0] ctr_pix, lft_pix, rgt_pix;

  logic adv, acc, issue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_width   <= lmwf_pkg::MARKER_WIDTH_RST;
      edge_threshold <= lmwf_pkg::EDGE_THRESHOLD_RST;
      image_columns  <= lmwf_pkg::IMAGE_COLUMNS_RST;
      image_rows     <= lmwf_pkg::IMAGE_ROWS_RST;
    end else if (cfg_valid) begin
      unique case (lmwf_pkg::cfg_reg_t'(cfg_index))
        lmwf_pkg::REG_MARKER_WIDTH:   marker_width   <= cfg_data[MW_W-1:0];
        lmwf_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[lmwf_pkg::THR_W-1:0];
        lmwf_pkg::REG_IMAGE_COLUMNS:  image_columns  <= cfg_data[lmwf_pkg::DIM_W-1:0];
        lmwf_pkg::REG_IMAGE_ROWS:     image_rows     <= cfg_data[lmwf_pkg::DIM_W-1:0];
      endcase
    end
  end

  // saturated width and dimensions (as last index)
  logic [MW_W-1:0]  w_sat;
  logic [EXT_W-1:0] w_ext;
  logic [AW-1:0]    w_a;
  logic [CNT_W-1:0] cols_m1, rows_m1;

  always_comb begin
    w_sat = (marker_width > MW_W'(MAX_MARKER_WIDTH)) ? MW_W'(MAX_MARKER_WIDTH) : marker_width;
    w_ext = EXT_W'(w_sat);
    w_a   = AW'(w_sat);
    if (image_columns == '0) begin
      cols_m1 = '0;
    end else if (32'(image_columns) > 32'(MAX_DIMENSION)) begin
      cols_m1 = CNT_W'(MAX_DIMENSION - 1);
    end else begin
      cols_m1 = CNT_W'(image_columns - 1'b1);
    end
    if (image_rows == '0) begin
      rows_m1 = '0;
    end else if (32'(image_rows) > 32'(MAX_DIMENSION)) begin
      rows_m1 = CNT_W'(MAX_DIMENSION - 1);
    end else begin
      rows_m1 = CNT_W'(image_rows - 1'b1);
    end
  end

  // handshake: the whole back end moves when the output register is free
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign issue         = s0_valid && adv;
  assign s_axis_tready = !s0_valid || (adv && (s0_x == s0_last));
  assign acc           = s_axis_tvalid && s_axis_tready;

  // position of the incoming pixel and the result range it opens
  logic [CNT_W-1:0] cc, rc, c, r, c_minus_w, first, last;
  logic             last_col, c_ge_w, has_res;

  always_comb begin
    cc        = s_axis_tuser ? '0 : column_count;
    rc        = s_axis_tuser ? '0 : row_count;
    c         = (cc > cols_m1) ? cols_m1 : cc;
    r         = (rc > rows_m1) ? rows_m1 : rc;
    last_col  = (c == cols_m1);
    c_ge_w    = ({1'b0, c} >= w_ext);
    c_minus_w = CNT_W'({1'b0, c} - w_ext);
    has_res   = last_col || c_ge_w;
    // flush at row end runs from c-W (or column 0) up to c
    if (last_col) begin
      first = c_ge_w ? c_minus_w : '0;
      last  = c;
    end else begin
      first = c_minus_w;
      last  = c_minus_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      wp           <= '0;
    end else if (acc) begin
      wp <= wp + 1'b1;
      if (last_col) begin
        column_count <= '0;
        row_count    <= (r == rows_m1) ? '0 : r + 1'b1;
      end else begin
        column_count <= c + 1'b1;
        row_count    <= r;
      end
    end
  end

  // a new job can only land when the current one issues its last column
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (acc && has_res) begin
      s0_valid <= 1'b1;
      s0_x     <= first;
      s0_last  <= last;
      s0_c     <= c;
      s0_r     <= r;
      s0_wp    <= wp + 1'b1;
    end else if (issue) begin
      if (s0_x == s0_last) begin
        s0_valid <= 1'b0;
      end else begin
        s0_x <= s0_x + 1'b1;
      end
    end
  end

  // window addresses: entry k steps back lives at wp - k
  // the pixel written at an accept edge sits one ahead of every address read then
  logic [AW-1:0]    k, ctr_addr, lft_addr, rgt_addr;
  logic [EXT_W-1:0] x_ext, xw, half_rows;

  always_comb begin
    k         = AW'(s0_c - s0_x);
    ctr_addr  = s0_wp - k;
    lft_addr  = s0_wp - k - w_a;
    rgt_addr  = s0_wp - k + w_a;
    x_ext     = {1'b0, s0_x};
    xw        = x_ext + w_ext;
    half_rows = ({1'b0, rows_m1} + EXT_W'(1)) >> 1;
    s1_next.ok        = ({1'b0, s0_r} >= half_rows) && (x_ext >= w_ext)
                        && (xw <= {1'b0, cols_m1}) && (xw <= {1'b0, s0_c});
    s1_next.row_end   = (s0_x == cols_m1);
    s1_next.frame_end = (s0_x == cols_m1) && (s0_r == rows_m1);
    s1_next.run_last  = (s0_x == s0_last);
  end

  // three copies of the pixel window, one read port each
  lmwf_ram #(.WIDTH(PW), .DEPTH(WIN_DEPTH)) u_win_ctr (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (wp + 1'b1),
    .wr_data (s_axis_tdata),
    .rd_en   (adv),
    .rd_addr (ctr_addr),
    .rd_data (ctr_pix)
  );

  lmwf_ram #(.WIDTH(PW), .DEPTH(WIN_DEPTH)) u_win_lft (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (wp + 1'b1),
    .wr_data (s_axis_tdata),
    .rd_en   (adv),
    .rd_addr (lft_addr),
    .rd_data (lft_pix)
  );

  lmwf_ram #(.WIDTH(PW), .DEPTH(WIN_DEPTH)) u_win_rgt (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (wp + 1'b1),
    .wr_data (s_axis_tdata),
    .rd_en   (adv),
    .rd_addr (rgt_addr),
    .rd_data (rgt_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s1       <= s1_next;
    end
  end

  // filter: 2c - l - r - |l - r| equals 2 * (c - max(l, r))
  logic [PW-1:0] mx, dlt, val;
  logic [PW:0]   dbl;
  logic          above, hit;

  always_comb begin
    mx    = (lft_pix > rgt_pix) ? lft_pix : rgt_pix;
    above = ctr_pix > mx;
    dlt   = ctr_pix - mx;
    dbl   = {dlt, 1'b0};
    val   = dbl[PW] ? lmwf_pkg::EDGE_ON : dbl[PW-1:0];
    hit   = s1.ok && (ctr_pix != '0) && above && (val > edge_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s1_valid;
      m_axis_tdata  <= hit ? lmwf_pkg::EDGE_ON : lmwf_pkg::EDGE_OFF;
      m_axis_tuser  <= {s1.frame_end, s1.row_end};
      m_axis_tlast  <= s1.run_last;
    end
  end

`ifndef SYNTHESIS
  a_job_range: assert property (@(posedge clk) disable iff (rst)
    s0_valid |-> (s0_x <= s0_last) && (EXT_W'(s0_last) - EXT_W'(s0_x) <= w_ext))
    else $error("issue stage walked outside its result range");

  a_hold_during_flush: assert property (@(posedge clk) disable iff (rst)
    s0_valid && (s0_x != s0_last) |-> !s_axis_tready)
    else $error("pixel taken while a flush is still being issued");

  a_row_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("row end word is not the last word of its pixel");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("frame end flagged away from a row end");
`endif

endmodule

// File: tb/lane_marking_width_filter_tb.sv
`timescale 1ns / 100ps

module lane_marking_width_filter_tb;

  localparam int DIM_LIMIT   = 4096;   // largest frame dimension the block accepts
  localparam int WIN_MASK    = 63;     // pixel history is 64 deep
  localparam int IDLE_SETTLE = 16;     // cycles left after the last word before a write

  // one marking word as it leaves m_axis
  typedef struct packed {
    logic [lmwf_pkg::PIXEL_W-1:0] level;
    logic                         row_end;
    logic                         frame_end;
    logic                         run_last;
  } marking_t;

  logic                             clk;
  logic                             rst;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [lmwf_pkg::PIXEL_W-1:0]     s_axis_tdata;   // pixel[7:0]
  logic                             s_axis_tuser;   // frame_start
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [lmwf_pkg::PIXEL_W-1:0]     m_axis_tdata;   // edge_value[7:0]
  logic [1:0]                       m_axis_tuser;   // [0] row_end, [1] frame_end
  logic                             m_axis_tlast;   // run_last
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lmwf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lmwf_pkg::CFG_DATA_W-1:0]  cfg_data;

  lane_marking_width_filter uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow copy of the filter state and registers
  logic [lmwf_pkg::PIXEL_W-1:0] line_window [64];   // entry k = pixel taken k words ago
  int                           col_pos;
  int                           row_pos;
  logic [lmwf_pkg::MW_W-1:0]    width_reg;
  logic [lmwf_pkg::THR_W-1:0]   thresh_reg;
  logic [lmwf_pkg::DIM_W-1:0]   cols_reg;
  logic [lmwf_pkg::DIM_W-1:0]   rows_reg;
  marking_t                     pending_markings [$];

  // idle profile of the current phase, in percent per cycle
  int gap_pct;
  int stall_pct;

  int fail_count;
  int pixel_count;
  int word_count;
  int lit_count;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake hangs
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // zero and oversized dimensions are pulled into 1..4096
  function automatic int clamp_dim(logic [lmwf_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > DIM_LIMIT) return DIM_LIMIT;
    return int'(v);
  endfunction

  // binary marking level for centre column x while column c is the newest pixel
  function automatic logic [lmwf_pkg::PIXEL_W-1:0] marking_level(int x, int c, int r, int w,
                                                                int cols, int rows);
    int ctr;
    int lft;
    int rgt;
    int diff;
    int v;
    // upper half of the frame is masked
    if (r < rows / 2) return lmwf_pkg::EDGE_OFF;
    // border columns and side samples not yet seen
    if (x < w || x + w >= cols || x + w > c) return lmwf_pkg::EDGE_OFF;
    ctr = int'(line_window[(c - x) & WIN_MASK]);
    lft = int'(line_window[(c - x + w) & WIN_MASK]);
    rgt = int'(line_window[(c - x - w) & WIN_MASK]);
    // a dark centre never marks
    if (ctr == 0) return lmwf_pkg::EDGE_OFF;
    diff = lft - rgt;
    if (diff < 0) diff = -diff;
    v = 2 * ctr - lft - rgt - diff;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return (v > int'(thresh_reg)) ? lmwf_pkg::EDGE_ON : lmwf_pkg::EDGE_OFF;
  endfunction

  // advance the shadow state by one pixel and queue the words it releases
  function automatic void predict_markings(logic [lmwf_pkg::PIXEL_W-1:0] pix, logic fs);
    int       w;
    int       cols;
    int       rows;
    int       c;
    int       r;
    int       first;
    int       last;
    int       k;
    int       x;
    marking_t m;
    w    = int'(width_reg);
    cols = clamp_dim(cols_reg);
    rows = clamp_dim(rows_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a counter left past a shrunk dimension reads as the last column or row
    c = (col_pos < cols) ? col_pos : cols - 1;
    r = (row_pos < rows) ? row_pos : rows - 1;
    for (k = WIN_MASK; k > 0; k--) line_window[k] = line_window[k-1];
    line_window[0] = pix;
    if (c == cols - 1) begin
      // last column flushes everything of the row still outstanding
      first = (c >= w) ? c - w : 0;
      last  = c;
    end else if (c >= w) begin
      first = c - w;
      last  = c - w;
    end else begin
      first = 1;
      last  = 0;
    end
    for (x = first; x <= last; x++) begin
      m.level     = marking_level(x, c, r, w, cols, rows);
      m.row_end   = (x == cols - 1);
      m.frame_end = m.row_end && (r == rows - 1);
      m.run_last  = (x == last);
      pending_markings.insert(pending_markings.size(), m);
    end
    if (c == cols - 1) begin
      col_pos = 0;
      row_pos = (r == rows - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // one process sees every handshake at the rising edge: register writes,
  // pixel words and marking words, so no ordering between processes matters
  always @(posedge clk) begin
    marking_t want;
    marking_t got;
    if (rst === 1'b0) begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          lmwf_pkg::REG_MARKER_WIDTH:   width_reg  = cfg_data[lmwf_pkg::MW_W-1:0];
          lmwf_pkg::REG_EDGE_THRESHOLD: thresh_reg = cfg_data[lmwf_pkg::THR_W-1:0];
          lmwf_pkg::REG_IMAGE_COLUMNS:  cols_reg   = cfg_data[lmwf_pkg::DIM_W-1:0];
          lmwf_pkg::REG_IMAGE_ROWS:     rows_reg   = cfg_data[lmwf_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) begin
        predict_markings(s_axis_tdata, s_axis_tuser);
        pixel_count++;
      end
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        word_count++;
        got.level     = m_axis_tdata;
        got.row_end   = m_axis_tuser[0];
        got.frame_end = m_axis_tuser[1];
        got.run_last  = m_axis_tlast;
        if (got.level == lmwf_pkg::EDGE_ON) lit_count++;
        if (pending_markings.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected marking word: level %0d row_end %0b frame_end %0b last %0b",
                   $time, got.level, got.row_end, got.frame_end, got.run_last);
        end else begin
          want = pending_markings.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: marking mismatch: expected level %0d row_end %0b frame_end %0b last %0b",
                     $time, want.level, want.row_end, want.frame_end, want.run_last);
            $display("%0t:                   actual   level %0d row_end %0b frame_end %0b last %0b",
                     $time, got.level, got.row_end, got.frame_end, got.run_last);
          end
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // entered at a falling edge; returns at the falling edge after the word is taken,
  // with tvalid still high so the next word can follow without a gap
  task automatic send_pixel(logic [lmwf_pkg::PIXEL_W-1:0] pix, logic fs);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding marking word drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_markings.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(lmwf_pkg::cfg_reg_t idx, logic [lmwf_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [lmwf_pkg::CFG_DATA_W-1:0] w,
                           logic [lmwf_pkg::CFG_DATA_W-1:0] thr,
                           logic [lmwf_pkg::CFG_DATA_W-1:0] cols,
                           logic [lmwf_pkg::CFG_DATA_W-1:0] rows);
    write_reg(lmwf_pkg::REG_MARKER_WIDTH, w);
    write_reg(lmwf_pkg::REG_EDGE_THRESHOLD, thr);
    write_reg(lmwf_pkg::REG_IMAGE_COLUMNS, cols);
    write_reg(lmwf_pkg::REG_IMAGE_ROWS, rows);
  endtask

  // grey levels biased towards dark, bright and the two extremes
  function automatic logic [lmwf_pkg::PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 40));
      3:       return 8'($urandom_range(180, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // power-up register values: wide marker, so a few pixels release nothing
  task automatic test_reset_values();
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hff, 1'b0);
    wait_idle();
  endtask

  // single-row frame, zero threshold, bright stripes on dark ground;
  // upper register bits set to show they are ignored
  task automatic test_filter_extremes();
    logic [lmwf_pkg::PIXEL_W-1:0] row [8];
    int i;
    row = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0};
    configure(13'h1fe2, 13'h1f00, 13'd8, 13'd1);
    for (i = 0; i < 8; i++) send_pixel(row[i], i == 0);
    wait_idle();
  endtask

  // row not wider than the marker: the whole row comes out at its last pixel
  task automatic test_narrow_rows();
    configure(13'd5, 13'd20, 13'd3, 13'd1);
    send_pixel(8'd90, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd15, 1'b0);
    wait_idle();
  endtask

  // zero marker width makes every filter value zero
  task automatic test_zero_width();
    int i;
    configure(13'd0, 13'd0, 13'd4, 13'd1);
    for (i = 0; i < 4; i++) send_pixel(random_pixel(), i == 0);
    wait_idle();
  endtask

  // zero dimensions become 1, oversized ones become 4096
  task automatic test_dimension_saturation();
    configure(13'd1, 13'd0, 13'd0, 13'd0);
    send_pixel(8'd77, 1'b1);
    send_pixel(8'd255, 1'b0);
    wait_idle();
    configure(13'd1, 13'd0, 13'h1fff, 13'h1fff);
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd1, 1'b0);
    wait_idle();
  endtask

  // shrink the row under a column counter already past the new width
  task automatic test_shrunk_dimension();
    configure(13'd1, 13'd10, 13'd6, 13'd1);
    send_pixel(8'd10, 1'b1);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd200, 1'b0);
    wait_idle();
    write_reg(lmwf_pkg::REG_IMAGE_COLUMNS, 13'd3);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd30, 1'b0);
    wait_idle();
  endtask

  // frames of random content with frame_start where it belongs,
  // plus an occasional stray frame_start
  task automatic run_phase(int gap, int stall, int w, int thr, int cols, int rows, int count);
    int frame_size;
    int i;
    logic fs;
    gap_pct   = gap;
    stall_pct = stall;
    configure(lmwf_pkg::CFG_DATA_W'(w), lmwf_pkg::CFG_DATA_W'(thr),
              lmwf_pkg::CFG_DATA_W'(cols), lmwf_pkg::CFG_DATA_W'(rows));
    frame_size = clamp_dim(lmwf_pkg::DIM_W'(cols)) * clamp_dim(lmwf_pkg::DIM_W'(rows));
    for (i = 0; i < count; i++) begin
      fs = (i % frame_size == 0) || ($urandom_range(0, 99) < 3);
      send_pixel(random_pixel(), fs);
    end
    wait_idle();
  endtask

  task automatic test_random_frames();
    // steady flow, small frames
    run_phase(0, 0, 3, $urandom_range(0, 255), 16, 4, 90);
    // widest marker on a 32 pixel row: every row end flushes 32 words
    run_phase(83, 0, 31, 0, 32, 1, 64);
    // narrowest marker, top threshold, heavy back-pressure
    run_phase(0, 83, 1, 255, 7, 3, 70);
    // everything random, light idling on both sides
    run_phase(12, 12, $urandom_range(1, 8), $urandom_range(0, 255),
              $urandom_range(2, 20), $urandom_range(1, 6), 120);
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    int k;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = lmwf_pkg::REG_MARKER_WIDTH;
    cfg_data      = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    fail_count    = 0;
    pixel_count   = 0;
    word_count    = 0;
    lit_count     = 0;
    // shadow state matches the block after reset
    for (k = 0; k <= WIN_MASK; k++) line_window[k] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = lmwf_pkg::MARKER_WIDTH_RST;
    thresh_reg = lmwf_pkg::EDGE_THRESHOLD_RST;
    cols_reg   = lmwf_pkg::IMAGE_COLUMNS_RST;
    rows_reg   = lmwf_pkg::IMAGE_ROWS_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_filter_extremes();
    test_narrow_rows();
    test_zero_width();
    test_dimension_saturation();
    test_shrunk_dimension();
    test_random_frames();

    wait_idle();
    $display("run covered %0d pixel words and %0d marking words (%0d lit), marker widths 0..31,",
             pixel_count, word_count, lit_count);
    $display("thresholds 0..255, frame sizes 1..4096, a shrunk row and four idle/stall profiles");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lmwf_pkg.sv
rtl/core/lmwf_ram.sv
rtl/core/lane_marking_width_filter.sv
tb/lane_marking_width_filter_tb.sv
